// ----- design/duty_ramp_ease_in_out_macros.svh -----
// ----------------------------------------------------------------------------
// duty_ramp_ease_in_out assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUTY_RAMP_EASE_IN_OUT_MACROS_SVH
`define DUTY_RAMP_EASE_IN_OUT_MACROS_SVH

`ifndef ASSERT_OFF
`define DRE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DRE_ASSERT(label, prop, msg)
`define DRE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/dreio_pkg.sv -----
// ----------------------------------------------------------------------------
// dreio_pkg
// Constants and command codes for the eased duty ramp.
// ----------------------------------------------------------------------------
package dreio_pkg;

	// parameter defaults
	localparam int TIME_BITS_DEF  = 24;
	localparam int FULL_SCALE_DEF = 10000;

	// fixed field widths
	localparam int MODE_W = 2;
	localparam int REQ_W  = 16;
	localparam int MS_W   = 24;
	localparam int DUTY_W_OUT = 14;
	localparam int IN_W   = 40;
	localparam int OUT_W  = 40;

	// Q16 progress
	localparam int Q_BITS = 16;
	localparam int CNT_W  = $clog2(Q_BITS);
	localparam int MUL_W  = Q_BITS + 1;
	localparam logic [MUL_W-1:0] Q_ONE = 17'h10000;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_SET  = 2'd0;
	localparam mode_t MODE_RAMP = 2'd1;
	localparam mode_t MODE_STOP = 2'd2;
	localparam mode_t MODE_TICK = 2'd3;

endpackage

// ----- design/duty_ramp_ease_in_out.sv -----
// Eased PWM duty ramp. Holds a duty in hundredths of a percent (0..FULL_SCALE)
// and moves it with set, ramp, stop and 1 ms tick requests; a ramp follows the
// quadratic ease-in-out curve. One request is worked at a time. Set, stop,
// ramp and a tick that starts no curve step go from acceptance straight to the
// result state. A tick that lands inside a ramp first runs the
// restoring divider that forms Q16 progress one quotient bit per cycle, then
// two passes through the single shared 17x17 multiplier (square, then scale)
// and the final add. A new request is accepted as soon as the sequencer is
// idle, even while the last result waits at the output register; a full
// output register delays only the next result.
// ----------------------------------------------------------------------------
// duty_ramp_ease_in_out
// Duty ramp with Q16 progress divider and shared multiplier sequencer.
// ----------------------------------------------------------------------------
`include "duty_ramp_ease_in_out_macros.svh"

module duty_ramp_ease_in_out #(
	parameter int TIME_BITS  = dreio_pkg::TIME_BITS_DEF,
	parameter int FULL_SCALE = dreio_pkg::FULL_SCALE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// config: enabled
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	// tdata: duty_request[15:0], ramp_ms[39:16]
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [dreio_pkg::IN_W-1:0] s_tdata,
	// tuser: mode[1:0]
	input  logic [dreio_pkg::MODE_W-1:0] s_tuser,
	// tdata: duty[13:0], ramping[14], running[15], remaining_ms[39:16]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [dreio_pkg::OUT_W-1:0] m_tdata
);
	import dreio_pkg::*;

	localparam int DUTY_W = $clog2(FULL_SCALE + 1);
	localparam logic [REQ_W:0]  FS_REQ  = (REQ_W+1)'(FULL_SCALE);
	localparam logic [DUTY_W-1:0] FS_DUTY = DUTY_W'(FULL_SCALE);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_SQR   = 3'd2;
	localparam logic [2:0] ST_EASE  = 3'd3;
	localparam logic [2:0] ST_SCALE = 3'd4;
	localparam logic [2:0] ST_APPLY = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]           st_q;
	logic                 enabled_q;
	logic [DUTY_W-1:0]    cur_q, start_q, target_q;
	logic [TIME_BITS-1:0] elapsed_q, len_q;
	logic                 anim_q;

	logic [TIME_BITS-1:0] rem_q;
	logic [Q_BITS-1:0]    quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [2*MUL_W-1:0]   prod_q;
	logic [MUL_W-1:0]     ease_q;
	logic [DUTY_W-1:0]    diff_q;
	logic                 down_q;

	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	// request decode
	mode_t                mode;
	logic [REQ_W-1:0]     req_raw;
	logic [DUTY_W-1:0]    req_clamp;
	logic [TIME_BITS-1:0] dur;
	logic [TIME_BITS-1:0] elapsed_nx;
	logic                 ramp_done;
	logic                 accept;

	assign mode    = s_tuser;
	assign req_raw = s_tdata[REQ_W-1:0];
	assign dur     = TIME_BITS'(s_tdata[REQ_W +: MS_W]);
	assign accept  = s_tvalid && s_tready;

	always_comb begin
		if (req_raw[REQ_W-1]) begin
			req_clamp = '0;
		end else if ({2'b00, req_raw[REQ_W-2:0]} > FS_REQ) begin
			req_clamp = FS_DUTY;
		end else begin
			req_clamp = DUTY_W'(req_raw[REQ_W-2:0]);
		end
	end

	assign elapsed_nx = elapsed_q + TIME_BITS'(1);
	assign ramp_done  = (elapsed_nx >= len_q) || (len_q == '0);

	// restoring divider step: (elapsed << 16) / len
	logic [TIME_BITS:0] div_sh, div_dif;
	logic               div_ge;
	assign div_sh  = {rem_q, 1'b0};
	assign div_ge  = div_sh >= {1'b0, len_q};
	assign div_dif = div_sh - {1'b0, len_q};

	// shared multiplier
	logic [MUL_W-1:0] sq_op, mul_a, mul_b;
	logic [Q_BITS-1:0] sq_shr;
	assign sq_op  = quot_q[Q_BITS-1] ? (Q_ONE - {1'b0, quot_q}) : {1'b0, quot_q};
	assign sq_shr = prod_q[Q_BITS-1 +: Q_BITS];

	always_comb begin
		if (st_q == ST_SCALE) begin
			mul_a = MUL_W'(diff_q);
			mul_b = ease_q;
		end else begin
			mul_a = sq_op;
			mul_b = sq_op;
		end
	end

	// result fields
	logic [MS_W-1:0]  remain;
	logic [OUT_W-1:0] result;
	logic             out_free;
	assign remain   = (anim_q && (len_q > elapsed_q)) ? MS_W'(len_q - elapsed_q) : '0;
	assign result   = {remain, (cur_q != '0) || anim_q, anim_q, DUTY_W_OUT'(cur_q)};
	assign out_free = !m_tvalid_q || m_tready;

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enabled_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			cnt_q      <= '0;
			cur_q      <= '0;
			start_q    <= '0;
			target_q   <= '0;
			elapsed_q  <= '0;
			len_q      <= '0;
			anim_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((st_q == ST_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_FIN;
						if (mode == MODE_TICK) begin
							if (anim_q) begin
								elapsed_q <= elapsed_nx;
								if (ramp_done) begin
									anim_q <= 1'b0;
									if (enabled_q) begin
										cur_q <= target_q;
									end
								end else begin
									cnt_q <= '0;
									st_q  <= ST_DIV;
								end
							end
						end else if (enabled_q) begin
							if (mode == MODE_STOP) begin
								cur_q <= '0;
							end else if (mode == MODE_SET || dur == '0) begin
								cur_q <= req_clamp;
							end else begin
								start_q   <= cur_q;
								target_q  <= req_clamp;
								elapsed_q <= '0;
								len_q     <= dur;
								anim_q    <= 1'b1;
							end
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(Q_BITS - 1)) begin
						st_q <= ST_SQR;
					end
				end
				ST_SQR:   st_q <= ST_EASE;
				ST_EASE:  st_q <= ST_SCALE;
				ST_SCALE: st_q <= ST_APPLY;
				ST_APPLY: begin
					if (down_q) begin
						cur_q <= start_q - prod_q[Q_BITS +: DUTY_W];
					end else begin
						cur_q <= start_q + prod_q[Q_BITS +: DUTY_W];
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				rem_q <= elapsed_nx;
			end
			ST_DIV: begin
				rem_q  <= div_ge ? div_dif[TIME_BITS-1:0] : div_sh[TIME_BITS-1:0];
				quot_q <= {quot_q[Q_BITS-2:0], div_ge};
			end
			ST_SQR: begin
				prod_q <= mul_a * mul_b;
			end
			ST_EASE: begin
				// upper half of the curve mirrors the lower one
				ease_q <= quot_q[Q_BITS-1] ? (Q_ONE - {1'b0, sq_shr}) : {1'b0, sq_shr};
				down_q <= target_q < start_q;
				diff_q <= (target_q < start_q) ? (start_q - target_q) : (target_q - start_q);
			end
			ST_SCALE: begin
				prod_q <= mul_a * mul_b;
			end
			ST_FIN: begin
				if (out_free) begin
					m_tdata_q <= result;
				end
			end
			default: begin
			end
		endcase
	end

	`DRE_ASSERT(a_duty_in_range, cur_q <= FS_DUTY, "duty above full scale")
	`DRE_ASSERT(a_elapsed_below_len, !anim_q || (elapsed_q < len_q),
		"ramp running past its length")
	`DRE_ASSERT(a_div_rem_below_len, (st_q != ST_DIV) || (rem_q < len_q),
		"divider remainder not below length")
	`DRE_ASSERT_NEXT(a_accept_busy, accept, st_q != ST_IDLE,
		"accepted request did not start work")

endmodule

// ----- dv/tb_duty_ramp_ease_in_out.sv -----
// ----------------------------------------------------------------------------
// tb_duty_ramp_ease_in_out
// Self-checking bench for the eased duty ramp. Set, ramp, stop and tick
// requests go in on the slave stream and every request gives one status word
// back. A local model of the duty, ramp timer and ease-in-out curve predicts
// each status word, and the bench compares it field by field. The enable
// register is toggled between traffic phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_duty_ramp_ease_in_out;
	timeunit 1ns;
	timeprecision 1ps;

	import dreio_pkg::*;

	localparam int FULL_SCALE = FULL_SCALE_DEF;

	typedef struct {
		mode_t       mode;
		logic [15:0] req;
		logic [23:0] ms;
	} duty_cmd_t;

	// duty in the lowest bits, remaining_ms on top
	typedef struct packed {
		logic [23:0] remaining_ms;
		logic        running;
		logic        ramping;
		logic [13:0] duty;
	} duty_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic [MODE_W-1:0] s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	duty_ramp_ease_in_out u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// model state
	logic        duty_en = 1'b0;
	logic [13:0] duty_now = '0;
	logic [13:0] duty_start = '0;
	logic [13:0] duty_target = '0;
	logic [23:0] ramp_elapsed = '0;
	logic [23:0] ramp_len = '0;
	logic        ramp_on = 1'b0;

	duty_cmd_t    pending_cmds[$];
	duty_status_t expected_status[$];
	duty_cmd_t    cmd_now;
	duty_status_t status_got;
	duty_status_t status_want;

	int idle_pct = 38;
	int error_count = 0;
	int checked_count = 0;
	int ramp_count = 0;
	int curve_ticks = 0;
	int cfg_writes = 0;
	int rx_cycle = 0;
	int hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d requests still expected", expected_status.size());
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= 50)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic duty_status_t predict_duty(input mode_t mode, input logic [15:0] raw,
			input logic [23:0] ms);
		logic [13:0] req;
		logic [63:0] frac;
		logic [63:0] eased;
		logic [63:0] inv;
		logic [63:0] span;
		duty_status_t res;
		if (raw[15])
			req = '0;
		else if (raw > FULL_SCALE)
			req = FULL_SCALE[13:0];
		else
			req = raw[13:0];

		if (mode == MODE_TICK) begin
			if (ramp_on) begin
				ramp_elapsed = ramp_elapsed + 24'd1;
				if (ramp_elapsed >= ramp_len || ramp_len == '0) begin
					ramp_on = 1'b0;
					// disabled completion leaves the eased duty in place
					if (duty_en)
						duty_now = duty_target;
				end else begin
					curve_ticks++;
					frac = (64'(ramp_elapsed) << 16) / 64'(ramp_len);
					if (frac < 64'd32768) begin
						eased = (frac * frac) >> 15;
					end else begin
						inv = 64'd65536 - frac;
						eased = 64'd65536 - ((inv * inv) >> 15);
					end
					if (duty_target >= duty_start) begin
						span = (64'(duty_target - duty_start) * eased) >> 16;
						duty_now = duty_start + span[13:0];
					end else begin
						span = (64'(duty_start - duty_target) * eased) >> 16;
						duty_now = duty_start - span[13:0];
					end
				end
			end
		end else if (duty_en) begin
			case (mode)
				MODE_SET: begin
					duty_now = req;
				end
				MODE_STOP: begin
					duty_now = '0;
				end
				default: begin
					if (ms == '0) begin
						duty_now = req;
					end else begin
						ramp_count++;
						duty_start = duty_now;
						duty_target = req;
						ramp_elapsed = '0;
						ramp_len = ms;
						ramp_on = 1'b1;
					end
				end
			endcase
		end

		res.duty = duty_now;
		res.ramping = ramp_on;
		res.running = (duty_now != '0) || ramp_on;
		res.remaining_ms = (ramp_on && ramp_len > ramp_elapsed) ? ramp_len - ramp_elapsed : '0;
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_status.push_back(predict_duty(s_tuser, s_tdata[15:0], s_tdata[39:16]));
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cmd_now = pending_cmds.pop_front();
					s_tuser <= cmd_now.mode;
					s_tdata <= {cmd_now.ms, cmd_now.req};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// status monitor; when rx_cycle reaches its hold-off period it holds off long enough to back up the input
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				status_got = m_tdata;
				if (expected_status.size() == 0) begin
					report_mismatch("unexpected status word", status_got, 0);
				end else begin
					status_want = expected_status.pop_front();
					checked_count++;
					if (status_got.duty !== status_want.duty)
						report_mismatch("duty", status_got.duty, status_want.duty);
					if (status_got.ramping !== status_want.ramping)
						report_mismatch("ramping", status_got.ramping, status_want.ramping);
					if (status_got.running !== status_want.running)
						report_mismatch("running", status_got.running, status_want.running);
					if (status_got.remaining_ms !== status_want.remaining_ms)
						report_mismatch("remaining_ms", status_got.remaining_ms,
							status_want.remaining_ms);
				end
			end
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_cycle % 7000 == 0) begin
				hold_left = 150;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic queue_cmd(input mode_t mode, input logic [15:0] req, input logic [23:0] ms);
		duty_cmd_t c;
		c.mode = mode;
		c.req = req;
		c.ms = ms;
		pending_cmds.push_back(c);
	endtask

	// sender holds back until every request has its status
	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_enable(input logic val);
		wait_quiet();
		@(posedge clk);
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		duty_en = val;
		cfg_writes++;
	endtask

	function automatic logic [15:0] rand_request();
		case ($urandom_range(9))
			0, 1: return 16'($urandom);
			2: return 16'(FULL_SCALE - 2 + $urandom_range(4));
			default: return 16'($urandom_range(FULL_SCALE));
		endcase
	endfunction

	function automatic logic [23:0] rand_ramp_len();
		case ($urandom_range(19))
			0, 1: return '0;
			2: return 24'($urandom);
			3, 4, 5, 6: return 24'($urandom_range(300, 1));
			default: return 24'($urandom_range(24, 1));
		endcase
	endfunction

	// mostly ramps followed by their ticks, with sets, stops and junk mixed in
	task automatic queue_random_traffic(input int n_items);
		int n;
		int ticks;
		logic [23:0] len;
		n = 0;
		while (n < n_items) begin
			if ($urandom_range(9) < 2) begin
				repeat ($urandom_range(3, 1)) begin
					queue_cmd(mode_t'($urandom_range(3)), 16'($urandom), 24'($urandom));
					n++;
				end
			end else begin
				len = rand_ramp_len();
				queue_cmd(MODE_RAMP, rand_request(), len);
				n++;
				ticks = (len <= 40) ? int'(len) + $urandom_range(3) : $urandom_range(40, 5);
				repeat (ticks) begin
					case ($urandom_range(24))
						0: queue_cmd(MODE_SET, rand_request(), 24'($urandom));
						1: queue_cmd(MODE_STOP, 16'($urandom), 24'($urandom));
						2: queue_cmd(MODE_RAMP, rand_request(), rand_ramp_len());
						default: queue_cmd(MODE_TICK, 16'($urandom), 24'($urandom));
					endcase
					n++;
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled: commands are ignored
		write_enable(1'b0);
		queue_cmd(MODE_SET, 16'd5000, '0);
		queue_cmd(MODE_RAMP, 16'd8000, 24'd4);
		queue_cmd(MODE_TICK, '0, '0);
		queue_cmd(MODE_STOP, '0, '0);

		write_enable(1'b1);
		// clamping at the extremes
		queue_cmd(MODE_SET, 16'h8000, '0);
		queue_cmd(MODE_SET, 16'h7FFF, '0);
		queue_cmd(MODE_SET, 16'd10001, '0);
		queue_cmd(MODE_SET, 16'd10000, '0);
		queue_cmd(MODE_RAMP, 16'd7000, '0);
		queue_cmd(MODE_TICK, '0, '0);
		// ramp through both halves of the curve
		queue_cmd(MODE_RAMP, 16'd0, 24'd5);
		repeat (3) queue_cmd(MODE_TICK, '0, '0);
		// set during a ramp, then the tick overwrites it
		queue_cmd(MODE_SET, 16'd2000, '0);
		queue_cmd(MODE_TICK, '0, '0);
		// ramp restarted from the current duty
		queue_cmd(MODE_RAMP, 16'd9000, 24'd3);
		queue_cmd(MODE_TICK, '0, '0);
		queue_cmd(MODE_STOP, '0, '0);
		repeat (3) queue_cmd(MODE_TICK, '0, '0);
		// longest ramp
		queue_cmd(MODE_RAMP, 16'hFFFF, 24'hFFFFFF);
		queue_cmd(MODE_TICK, 16'hFFFF, 24'hFFFFFF);
		queue_cmd(MODE_RAMP, 16'd10000, 24'd2);
		queue_cmd(MODE_TICK, '0, '0);

		// ramp ends while disabled: duty keeps its eased value
		write_enable(1'b0);
		queue_cmd(MODE_TICK, '0, '0);
		queue_cmd(MODE_TICK, '0, '0);
		queue_cmd(MODE_SET, 16'd3000, '0);

		for (int phase = 0; phase < 8; phase++) begin
			write_enable(phase != 4);
			idle_pct = (phase == 2) ? 0 : 38;
			queue_random_traffic((phase == 4) ? 75 : 225);
		end
		idle_pct = 38;

		wait_quiet();
		repeat (30) @(posedge clk);
		$display("Checked %0d status words: %0d ramps, %0d eased ticks, %0d enable writes",
			checked_count, ramp_count, curve_ticks, cfg_writes);
		$display("Receiver hold-offs backed up the input; %0d mismatches", error_count);
		if (error_count == 0 && expected_status.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
